[rtl/core/dlfs_pkg.sv]
package dlfs_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;

    localparam logic [7:0] DELIMITER_RESET    = 8'd44;
    localparam logic [7:0] COMMENT_CHAR_RESET = 8'd35;
    localparam logic [5:0] LAST_COLUMN_RESET  = 6'd63;
    localparam logic [6:0] COLUMN_INDEX_MAX   = 7'd127;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELIMITER          = 3'd0,
        CFG_COMMENT_ENABLE     = 3'd1,
        CFG_COMMENT_CHAR       = 3'd2,
        CFG_SKIP_LEADING_SPACE = 3'd3,
        CFG_SELECT_ALL         = 3'd4,
        CFG_COLUMN_MASK        = 3'd5,
        CFG_LAST_COLUMN        = 3'd6
    } cfg_index_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_MANY = 2'd1,
        ERR_TOO_LONG = 2'd2
    } err_code_t;

    typedef struct packed {
        logic [15:0] field_start;
        logic [15:0] field_end;
        logic [5:0]  field_slot;
        err_code_t   error_code;
        logic        end_of_line;
    } result_t;

endpackage

[rtl/core/dlfs_byte_if.sv]
interface dlfs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] line_byte;
    logic       last_byte;

    modport source (output valid, output line_byte, output last_byte, input ready);
    modport sink (input valid, input line_byte, input last_byte, output ready);
endinterface

[rtl/core/dlfs_field_if.sv]
interface dlfs_field_if;
    logic        valid;
    logic        ready;
    logic [15:0] field_start;
    logic [15:0] field_end;
    logic [5:0]  field_slot;
    logic [1:0]  error_code;
    logic        end_of_line;

    modport source (output valid, output field_start, output field_end, output field_slot,
                    output error_code, output end_of_line, input ready);
    modport sink (input valid, input field_start, input field_end, input field_slot,
                  input error_code, input end_of_line, output ready);
endinterface

[rtl/core/delimited_line_field_splitter.sv]
// Splits a text line, presented one byte per request with a flag on the last byte, into
// fields at the programmable delimiter and reports the start and end byte offsets of each
// selected column. The line ends at CR, LF, the optional comment byte, the flagged last
// byte, or after the delimiter that closes last_column when select_all is 0. One byte is
// accepted every clock cycle while the queue holds at most two results; a byte yields
// zero, one or two results (two for a delimiter on the flagged last byte), which are
// placed in a four-entry result queue that drains one result per cycle while the
// receiver is ready. Registers are to be written by the user only while the block is
// idle; the block itself does not enforce it.
module delimited_line_field_splitter
    import dlfs_pkg::*;
#(
    parameter int MAX_FIELDS       = 64,
    parameter int MAX_FIELD_LENGTH = 256,
    parameter int LINE_OFFSET_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    dlfs_byte_if.sink              line_ch,
    dlfs_field_if.source           field_ch,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    localparam int OFF_W = LINE_OFFSET_BITS;
    localparam int LEN_W = $clog2(MAX_FIELD_LENGTH);
    localparam int FS_W  = $clog2(MAX_FIELDS + 1);

    logic [7:0]  delimiter_reg, delimiter_next;
    logic        comment_enable_reg, comment_enable_next;
    logic [7:0]  comment_char_reg, comment_char_next;
    logic        skip_leading_space_reg, skip_leading_space_next;
    logic        select_all_reg, select_all_next;
    logic [63:0] column_mask_reg, column_mask_next;
    logic [5:0]  last_column_reg, last_column_next;

    logic [OFF_W-1:0] byte_offset_reg, byte_offset_next;
    logic [6:0]       column_index_reg, column_index_next;
    logic [FS_W-1:0]  fields_stored_reg, fields_stored_next;
    logic [LEN_W-1:0] field_length_reg, field_length_next;
    logic             column_selected_reg, column_selected_next;
    logic             line_done_reg, line_done_next;

    result_t    result_q_reg [4];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    logic    in_fire;
    logic    out_fire;
    logic    emit_a, emit_b;
    result_t res_a, res_b;
    logic [1:0] push_n;
    result_t push0, push1;

    function automatic logic selected_at(input logic [6:0] col, input logic sa,
                                         input logic [63:0] mask);
        logic hit;
        hit = 1'b0;
        if (col[6] == 1'b0)
        begin
            hit = mask[col[5:0]];
        end
        return sa | hit;
    endfunction

    function automatic logic [15:0] to16(input logic [OFF_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

    function automatic logic [5:0] to_slot(input logic [FS_W-1:0] v);
        logic [6:0] w;
        w = 7'(v);
        return w[5:0];
    endfunction

    assign in_fire  = line_ch.valid & line_ch.ready;
    assign out_fire = field_ch.valid & field_ch.ready;

    assign line_ch.ready = (count_reg <= 3'd2);

    always_comb
    begin
        delimiter_next          = delimiter_reg;
        comment_enable_next     = comment_enable_reg;
        comment_char_next       = comment_char_reg;
        skip_leading_space_next = skip_leading_space_reg;
        select_all_next         = select_all_reg;
        column_mask_next        = column_mask_reg;
        last_column_next        = last_column_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                CFG_DELIMITER:          delimiter_next = wr_data[7:0];
                CFG_COMMENT_ENABLE:     comment_enable_next = wr_data[0];
                CFG_COMMENT_CHAR:       comment_char_next = wr_data[7:0];
                CFG_SKIP_LEADING_SPACE: skip_leading_space_next = wr_data[0];
                CFG_SELECT_ALL:         select_all_next = wr_data[0];
                CFG_COLUMN_MASK:        column_mask_next = wr_data;
                CFG_LAST_COLUMN:        last_column_next = wr_data[5:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        logic [OFF_W-1:0] off;
        logic [6:0]       col;
        logic [FS_W-1:0]  fs;
        logic [LEN_W-1:0] len;
        logic [LEN_W:0]   len_inc;
        logic             sel;
        logic             done;
        logic [7:0]       b;

        off  = byte_offset_reg;
        col  = column_index_reg;
        fs   = fields_stored_reg;
        len  = field_length_reg;
        sel  = column_selected_reg;
        done = line_done_reg;
        b    = line_ch.line_byte;
        len_inc = '0;

        emit_a = 1'b0;
        emit_b = 1'b0;
        res_a  = '0;
        res_b  = '0;

        // A register write before the first byte of a line re-evaluates column zero.
        if (wr_en && (wr_index <= CFG_LAST_COLUMN) && (off == '0) && (col == '0) && !done)
        begin
            sel = selected_at(7'd0, select_all_next, column_mask_next);
        end

        if (in_fire)
        begin
            if (!done)
            begin
                if (b == delimiter_reg)
                begin
                    if (sel)
                    begin
                        emit_a = 1'b1;
                        if (fs >= FS_W'(MAX_FIELDS))
                        begin
                            res_a = '{16'd0, 16'd0, to_slot(fs), ERR_TOO_MANY, 1'b1};
                            done  = 1'b1;
                        end
                        else
                        begin
                            res_a = '{to16(off - OFF_W'(len)), to16(off), to_slot(fs),
                                      ERR_NONE, 1'b0};
                            fs    = FS_W'(fs + 1'b1);
                        end
                    end
                    if (!done)
                    begin
                        if (col < COLUMN_INDEX_MAX)
                        begin
                            col = col + 7'd1;
                        end
                        if (!select_all_reg && (col > {1'b0, last_column_reg}))
                        begin
                            res_a.end_of_line = 1'b1;
                            done = 1'b1;
                        end
                        else
                        begin
                            sel = selected_at(col, select_all_reg, column_mask_reg);
                            len = '0;
                        end
                    end
                end
                else if ((comment_enable_reg && (b == comment_char_reg)) || (b == CH_LF)
                         || (b == CH_CR))
                begin
                    if (sel)
                    begin
                        emit_a = 1'b1;
                        if (fs >= FS_W'(MAX_FIELDS))
                        begin
                            res_a = '{16'd0, 16'd0, to_slot(fs), ERR_TOO_MANY, 1'b1};
                        end
                        else
                        begin
                            res_a = '{to16(off - OFF_W'(len)), to16(off), to_slot(fs),
                                      ERR_NONE, 1'b1};
                            fs    = FS_W'(fs + 1'b1);
                        end
                    end
                    done = 1'b1;
                end
                else if (!sel)
                begin
                    len = len;
                end
                else if ((b == CH_SPACE) && (len == '0) && skip_leading_space_reg)
                begin
                    len = len;
                end
                else
                begin
                    len_inc = {1'b0, len} + 1'b1;
                    if (len_inc >= (LEN_W + 1)'(MAX_FIELD_LENGTH))
                    begin
                        emit_a = 1'b1;
                        res_a  = '{16'd0, 16'd0, to_slot(fs), ERR_TOO_LONG, 1'b1};
                        done   = 1'b1;
                    end
                    else
                    begin
                        len = len_inc[LEN_W-1:0];
                    end
                end

                off = off + 1'b1;

                if (line_ch.last_byte && !done)
                begin
                    if (sel)
                    begin
                        emit_b = 1'b1;
                        if (fs >= FS_W'(MAX_FIELDS))
                        begin
                            res_b = '{16'd0, 16'd0, to_slot(fs), ERR_TOO_MANY, 1'b1};
                        end
                        else
                        begin
                            res_b = '{to16(off - OFF_W'(len)), to16(off), to_slot(fs),
                                      ERR_NONE, 1'b1};
                            fs    = FS_W'(fs + 1'b1);
                        end
                    end
                    done = 1'b1;
                end
            end

            if (line_ch.last_byte)
            begin
                off  = '0;
                col  = '0;
                fs   = '0;
                len  = '0;
                done = 1'b0;
                sel  = selected_at(7'd0, select_all_reg, column_mask_reg);
            end
        end

        byte_offset_next     = off;
        column_index_next    = col;
        fields_stored_next   = fs;
        field_length_next    = len;
        column_selected_next = sel;
        line_done_next       = done;
    end

    always_comb
    begin
        push0  = emit_a ? res_a : res_b;
        push1  = res_b;
        push_n = {1'b0, emit_a} + {1'b0, emit_b};
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, out_fire};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, out_fire};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg          <= DELIMITER_RESET;
            comment_enable_reg     <= 1'b0;
            comment_char_reg       <= COMMENT_CHAR_RESET;
            skip_leading_space_reg <= 1'b0;
            select_all_reg         <= 1'b1;
            column_mask_reg        <= '0;
            last_column_reg        <= LAST_COLUMN_RESET;
            byte_offset_reg        <= '0;
            column_index_reg       <= '0;
            fields_stored_reg      <= '0;
            field_length_reg       <= '0;
            column_selected_reg    <= 1'b1;
            line_done_reg          <= 1'b0;
            wr_ptr_reg             <= '0;
            rd_ptr_reg             <= '0;
            count_reg              <= '0;
        end
        else
        begin
            delimiter_reg          <= delimiter_next;
            comment_enable_reg     <= comment_enable_next;
            comment_char_reg       <= comment_char_next;
            skip_leading_space_reg <= skip_leading_space_next;
            select_all_reg         <= select_all_next;
            column_mask_reg        <= column_mask_next;
            last_column_reg        <= last_column_next;
            byte_offset_reg        <= byte_offset_next;
            column_index_reg       <= column_index_next;
            fields_stored_reg      <= fields_stored_next;
            field_length_reg       <= field_length_next;
            column_selected_reg    <= column_selected_next;
            line_done_reg          <= line_done_next;
            wr_ptr_reg             <= wr_ptr_next;
            rd_ptr_reg             <= rd_ptr_next;
            count_reg              <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            result_q_reg[wr_ptr_reg] <= push0;
        end
        if (push_n == 2'd2)
        begin
            result_q_reg[wr_ptr_reg + 2'd1] <= push1;
        end
    end

    assign field_ch.valid       = (count_reg != 3'd0);
    assign field_ch.field_start = result_q_reg[rd_ptr_reg].field_start;
    assign field_ch.field_end   = result_q_reg[rd_ptr_reg].field_end;
    assign field_ch.field_slot  = result_q_reg[rd_ptr_reg].field_slot;
    assign field_ch.error_code  = result_q_reg[rd_ptr_reg].error_code;
    assign field_ch.end_of_line = result_q_reg[rd_ptr_reg].end_of_line;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 3'd4)
        else $error("Result queue holds more than four entries.");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && line_done_reg) |-> (push_n == 2'd0))
        else $error("A result was produced after the line had ended.");

    a_error_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_a && (res_a.error_code != ERR_NONE)) |-> (res_a.end_of_line && !emit_b))
        else $error("An error result did not end the line.");

    a_new_line: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && line_ch.last_byte) |=>
            ((byte_offset_reg == '0) && (column_index_reg == '0) && !line_done_reg))
        else $error("Line state was not cleared after the last byte.");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (LEN_W + 1)'(field_length_reg) < (LEN_W + 1)'(MAX_FIELD_LENGTH))
        else $error("Field length reached its limit without an error.");

endmodule

[tb/delimited_line_field_splitter_tb.sv]
module delimited_line_field_splitter_tb;
    import dlfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FIELDS       = 64;
    localparam int MAX_FIELD_LENGTH = 256;
    localparam int SETTLE_CYCLES    = 16;
    localparam int RANDOM_BYTES     = 50;
    localparam int LONG_HOLD_CYCLES = 400;

    typedef struct packed {
        logic [7:0] value;
        logic       is_last;
    } line_char_t;

    logic                   clk;
    logic                   rst_n;
    logic                   wr_en;
    logic [CFG_INDEX_W-1:0] wr_index;
    logic [CFG_DATA_W-1:0]  wr_data;

    dlfs_byte_if  line_ch ();
    dlfs_field_if field_ch ();

    delimited_line_field_splitter i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .line_ch  (line_ch),
        .field_ch (field_ch),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    line_char_t byte_queue[$];
    result_t    field_expect[$];
    int         mismatches   = 0;
    int         bytes_in     = 0;
    int         random_bytes = 0;
    bit         byte_taken   = 1'b0;

    logic [7:0]  cfg_delim;
    logic        cfg_cmt_en;
    logic [7:0]  cfg_cmt_char;
    logic        cfg_skip_sp;
    logic        cfg_sel_all;
    logic [63:0] cfg_mask;
    logic [5:0]  cfg_last_col;

    logic [15:0] line_pos;
    logic [6:0]  col_idx;
    logic [6:0]  n_emitted;
    logic [8:0]  fld_len;
    bit          col_sel;
    bit          line_over;

    int burst_left = 0;
    int gap_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int rx_mode = 0;
    int mode_left = 0;
    logic [7:0] rx_pattern = '0;
    logic [2:0] rx_phase = '0;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic bit column_on(input logic [6:0] col);
        if (cfg_sel_all)
            return 1'b1;
        if (col >= 7'd64)
            return 1'b0;
        return cfg_mask[col[5:0]];
    endfunction

    task automatic start_line();
        line_pos  = '0;
        col_idx   = '0;
        n_emitted = '0;
        fld_len   = '0;
        line_over = 1'b0;
        col_sel   = column_on(7'd0);
    endtask

    task automatic reset_splitter_model();
        cfg_delim    = DELIMITER_RESET;
        cfg_cmt_en   = 1'b0;
        cfg_cmt_char = COMMENT_CHAR_RESET;
        cfg_skip_sp  = 1'b0;
        cfg_sel_all  = 1'b1;
        cfg_mask     = '0;
        cfg_last_col = LAST_COLUMN_RESET;
        start_line();
    endtask

    task automatic emit_field(input logic [15:0] fend, input logic eol);
        result_t r;
        if (!col_sel)
            return;
        if (n_emitted >= 7'(MAX_FIELDS)) begin
            r.field_start = '0;
            r.field_end   = '0;
            r.field_slot  = n_emitted[5:0];
            r.error_code  = ERR_TOO_MANY;
            r.end_of_line = 1'b1;
            line_over     = 1'b1;
        end else begin
            r.field_start = fend - 16'(fld_len);
            r.field_end   = fend;
            r.field_slot  = n_emitted[5:0];
            r.error_code  = ERR_NONE;
            r.end_of_line = eol;
            n_emitted++;
        end
        field_expect.push_back(r);
    endtask

    task automatic split_byte(input logic [7:0] b, input logic is_last);
        result_t    r;
        logic [6:0] next_col;
        bit         stop;
        if (!line_over) begin
            if (b == cfg_delim) begin
                next_col = (col_idx < COLUMN_INDEX_MAX) ? col_idx + 7'd1 : col_idx;
                stop     = !cfg_sel_all && (next_col > {1'b0, cfg_last_col});
                emit_field(line_pos, stop);
                if (!line_over) begin
                    col_idx = next_col;
                    if (stop) begin
                        line_over = 1'b1;
                    end else begin
                        col_sel = column_on(col_idx);
                        fld_len = '0;
                    end
                end
            end else if ((cfg_cmt_en && b == cfg_cmt_char) || b == CH_LF || b == CH_CR) begin
                emit_field(line_pos, 1'b1);
                line_over = 1'b1;
            end else if (!col_sel) begin
            end else if (b == CH_SPACE && fld_len == 0 && cfg_skip_sp) begin
            end else begin
                fld_len++;
                if (fld_len >= 9'(MAX_FIELD_LENGTH)) begin
                    r.field_start = '0;
                    r.field_end   = '0;
                    r.field_slot  = n_emitted[5:0];
                    r.error_code  = ERR_TOO_LONG;
                    r.end_of_line = 1'b1;
                    field_expect.push_back(r);
                    line_over = 1'b1;
                end
            end
            line_pos++;
            if (is_last && !line_over) begin
                emit_field(line_pos, 1'b1);
                line_over = 1'b1;
            end
        end
        if (is_last)
            start_line();
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [63:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_DELIMITER:          cfg_delim    = val[7:0];
            CFG_COMMENT_ENABLE:     cfg_cmt_en   = val[0];
            CFG_COMMENT_CHAR:       cfg_cmt_char = val[7:0];
            CFG_SKIP_LEADING_SPACE: cfg_skip_sp  = val[0];
            CFG_SELECT_ALL:         cfg_sel_all  = val[0];
            CFG_COLUMN_MASK:        cfg_mask     = val;
            CFG_LAST_COLUMN:        cfg_last_col = val[5:0];
            default: ;
        endcase
        if (line_pos == 0 && col_idx == 0 && !line_over)
            col_sel = column_on(7'd0);
    endtask

    task automatic wait_idle();
        while (byte_queue.size() != 0 || line_ch.valid || field_expect.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_byte(input logic [7:0] value, input logic is_last);
        line_char_t c;
        c.value   = value;
        c.is_last = is_last;
        byte_queue.push_back(c);
    endtask

    task automatic push_text(input string s, input bit ends_line);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], ends_line && (i == s.len() - 1));
    endtask

    task automatic push_random_line(input bit ends_line);
        int         len;
        int         pick;
        logic [7:0] b;
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                b = cfg_delim;
            else if (pick < 35)
                b = CH_SPACE;
            else if (pick < 39)
                b = (pick == 36) ? CH_CR : (pick == 37) ? CH_LF : cfg_cmt_char;
            else
                b = 8'($urandom_range(0, 255));
            push_byte(b, ends_line && (i == len - 1));
        end
        random_bytes += len;
    endtask

    task automatic write_random_config();
        logic [7:0] delim;
        logic [7:0] cmt;
        case ($urandom_range(0, 7))
            0:       delim = 8'd0;
            1:       delim = 8'd255;
            2:       delim = CH_LF;
            3:       delim = CH_SPACE;
            4, 5:    delim = DELIMITER_RESET;
            default: delim = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 5))
            0:       cmt = delim;
            1:       cmt = 8'd0;
            2:       cmt = 8'd255;
            3:       cmt = COMMENT_CHAR_RESET;
            default: cmt = 8'($urandom_range(0, 255));
        endcase
        write_reg(CFG_DELIMITER, 64'(delim));
        write_reg(CFG_COMMENT_CHAR, 64'(cmt));
        write_reg(CFG_COMMENT_ENABLE, 64'($urandom_range(0, 1)));
        write_reg(CFG_SKIP_LEADING_SPACE, 64'($urandom_range(0, 1)));
        write_reg(CFG_SELECT_ALL, 64'($urandom_range(0, 1)));
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_COLUMN_MASK, '1);
            1:       write_reg(CFG_COLUMN_MASK, '0);
            default: write_reg(CFG_COLUMN_MASK, {32'($urandom), 32'($urandom)});
        endcase
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_LAST_COLUMN, 64'd0);
            1:       write_reg(CFG_LAST_COLUMN, 64'd63);
            default: write_reg(CFG_LAST_COLUMN, 64'($urandom_range(0, 8)));
        endcase
    endtask

    always @(negedge clk) begin : line_driver
        line_char_t next_char;
        if (rst_n) begin
            if (!line_ch.valid || byte_taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    line_ch.valid <= 1'b0;
                end else if (byte_queue.size() > 0) begin
                    next_char = byte_queue.pop_front();
                    line_ch.line_byte <= next_char.value;
                    line_ch.last_byte <= next_char.is_last;
                    line_ch.valid     <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    line_ch.valid <= 1'b0;
                end
            end
        end else begin
            line_ch.valid     <= 1'b0;
            line_ch.line_byte <= '0;
            line_ch.last_byte <= 1'b0;
        end
    end

    always @(negedge clk) begin : field_receiver
        if (rst_n) begin
            if (hold_left > 0) begin
                hold_left--;
                field_ch.ready <= 1'b0;
            end else if (!long_hold_done && bytes_in >= 40 && byte_queue.size() > 30) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES;
                field_ch.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode    = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 96);
                    rx_pattern = 8'($urandom);
                end else begin
                    mode_left--;
                end
                case (rx_mode)
                    2:       field_ch.ready <= 1'($urandom_range(0, 1));
                    3:       field_ch.ready <= rx_pattern[rx_phase];
                    default: field_ch.ready <= 1'b1;
                endcase
                rx_phase++;
            end
        end else begin
            field_ch.ready <= 1'b0;
        end
    end

    always @(posedge clk) begin : field_monitor
        result_t want;
        byte_taken <= line_ch.valid && line_ch.ready;
        if (rst_n) begin
            if (field_ch.valid && field_ch.ready) begin
                if (field_expect.size() == 0) begin
                    report_mismatch("unexpected result, field_end", field_ch.field_end, '0);
                end else begin
                    want = field_expect.pop_front();
                    if (field_ch.field_start !== want.field_start)
                        report_mismatch("field_start", field_ch.field_start, want.field_start);
                    if (field_ch.field_end !== want.field_end)
                        report_mismatch("field_end", field_ch.field_end, want.field_end);
                    if (field_ch.field_slot !== want.field_slot)
                        report_mismatch("field_slot", 16'(field_ch.field_slot),
                                        16'(want.field_slot));
                    if (field_ch.error_code !== want.error_code)
                        report_mismatch("error_code", 16'(field_ch.error_code),
                                        16'(want.error_code));
                    if (field_ch.end_of_line !== want.end_of_line)
                        report_mismatch("end_of_line", 16'(field_ch.end_of_line),
                                        16'(want.end_of_line));
                end
            end
            if (line_ch.valid && line_ch.ready) begin
                bytes_in++;
                split_byte(line_ch.line_byte, line_ch.last_byte);
            end
        end
    end

    initial begin
        rst_n              = 1'b0;
        wr_en              = 1'b0;
        wr_index           = '0;
        wr_data            = '0;
        reset_splitter_model();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_idle();

        // Default settings: empty fields, a delimiter on the flagged last byte,
        // CR and LF ending the line early, and all-zero and all-one bytes.
        push_text("ab,,c", 1'b1);
        push_text("x,", 1'b1);
        push_text("q1\rzz", 1'b1);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b1);
        push_text("a\nb", 1'b1);
        wait_idle();

        write_reg(CFG_SKIP_LEADING_SPACE, 64'd1);
        write_reg(CFG_COMMENT_ENABLE, 64'd1);
        write_reg(CFG_COMMENT_CHAR, 64'(COMMENT_CHAR_RESET));
        push_text("  a, b #c", 1'b1);
        wait_idle();

        // Early stop after column two, then a line whose closing column is not selected.
        write_reg(CFG_SELECT_ALL, 64'd0);
        write_reg(CFG_COLUMN_MASK, 64'h5);
        write_reg(CFG_LAST_COLUMN, 64'd2);
        push_text("aa,bb,cc,dd", 1'b1);
        wait_idle();
        write_reg(CFG_COLUMN_MASK, 64'h1);
        write_reg(CFG_LAST_COLUMN, 64'd63);
        push_text("a,b", 1'b1);
        wait_idle();

        // A delimiter equal to LF acts as a delimiter.
        write_reg(CFG_SELECT_ALL, 64'd1);
        write_reg(CFG_COMMENT_ENABLE, 64'd0);
        write_reg(CFG_DELIMITER, 64'(CH_LF));
        push_text("a\nb\r", 1'b1);
        wait_idle();

        write_reg(CFG_DELIMITER, 64'd0);
        write_reg(CFG_COMMENT_CHAR, 64'd255);
        write_reg(CFG_COMMENT_ENABLE, 64'd1);
        push_byte(8'h00, 1'b0);
        push_byte("k", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte("m", 1'b1);
        wait_idle();

        // Too many fields, then a field that grows too long.
        write_reg(CFG_DELIMITER, 64'(DELIMITER_RESET));
        write_reg(CFG_COMMENT_ENABLE, 64'd0);
        write_reg(CFG_SKIP_LEADING_SPACE, 64'd0);
        for (int i = 0; i < MAX_FIELDS + 1; i++)
            push_byte(DELIMITER_RESET, 1'b0);
        push_byte("x", 1'b1);
        for (int i = 0; i < MAX_FIELD_LENGTH; i++)
            push_byte("a", 1'b0);
        push_byte("b", 1'b1);
        wait_idle();

        write_reg(CFG_SELECT_ALL, 64'd0);
        write_reg(CFG_COLUMN_MASK, '1);
        write_reg(CFG_LAST_COLUMN, 64'd0);
        push_text("a,b", 1'b1);
        wait_idle();

        while (random_bytes < RANDOM_BYTES) begin
            write_random_config();
            repeat ($urandom_range(3, 8))
                push_random_line(1'b1);
            if ($urandom_range(0, 3) == 0)
                push_random_line(1'b0);
            wait_idle();
        end

        // Close any open line.
        push_byte("z", 1'b1);
        wait_idle();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && field_expect.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[delimited_line_field_splitter.f]
rtl/core/dlfs_pkg.sv
rtl/core/dlfs_byte_if.sv
rtl/core/dlfs_field_if.sv
rtl/core/delimited_line_field_splitter.sv
tb/delimited_line_field_splitter_tb.sv
